// ===== rtl/dtsc_pkg.sv =====
package dtsc_pkg;

   // Field widths
   localparam int CNT_W    = 64;
   localparam int TIME_W   = 32;
   localparam int THRESH_W = 7;
   localparam int CFG16_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Scaled products: a 64-bit delta times a 7-bit factor
   localparam int PROD_W = CNT_W + THRESH_W;

   // Configuration reset values
   localparam logic                PRESENT_RST   = 1'b1;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 7'd10;
   localparam logic [CFG16_W-1:0]  RATE_RST      = 16'd0;
   localparam logic [CFG16_W-1:0]  DURATION_RST  = 16'd5;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_ON     = 2'd1,
      EV_EXTEND = 2'd2,
      EV_OFF    = 2'd3
   } mode_event_type;

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_ARMED,
      MODE_SAMPLING
   } mode_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESENT   = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_RATE      = 2'd2,
      CSR_DURATION  = 2'd3
   } csr_index_type;

   // Per-type new-drop flags
   typedef struct packed {
      logic raw_out;
      logic ign_out;
      logic sniff;
      logic match;
      logic enc;
   } drop_flags_type;

   // One check handed to the mode controller
   typedef struct packed {
      logic                load;
      logic                present;
      logic                overload;
      logic                rate_nz;
      logic [TIME_W-1:0]   now;
      logic [CFG16_W-1:0]  duration;
   } mode_req_type;

   // Mode controller state as seen by the result channel
   typedef struct packed {
      logic                sampling_on;
      logic                armed;
      mode_event_type      event_code;
      logic [TIME_W-1:0]   sampling_end;
   } mode_stat_type;

endpackage

// ===== rtl/drop_triggered_sampling_control.sv =====
// Channel   | Direction | Handshake          | Payload
// req_      | in        | req_valid/req_stall| now_seconds, seven 64-bit counters
// rsp_      | out       | rsp_valid/rsp_stall| mode, arm flag, event, end, drop sum, flags
// csr_      | in        | csr_valid/csr_ready| csr_index, csr_wdata (always ready)
//
// One request per cycle while req_stall is low; each result passes through the stages below.
// Stages: input register, counter deltas, scaled products, overload compare
// with mode update into the result register.
// rsp_stall holds the result register and backs up through the stages;
// empty stages still take new requests.
// Reset is synchronous and restores the configuration defaults.
module drop_triggered_sampling_control
   import dtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_seconds,
   input  logic [CNT_W-1:0]      req_sniffed_total,
   input  logic [CNT_W-1:0]      req_sniff_dropped_total,
   input  logic [CNT_W-1:0]      req_raw_total,
   input  logic [CNT_W-1:0]      req_encoder_drop_total,
   input  logic [CNT_W-1:0]      req_matcher_drop_total,
   input  logic [CNT_W-1:0]      req_raw_out_drop_total,
   input  logic [CNT_W-1:0]      req_ignored_out_drop_total,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_sampling_on,
   output logic                  rsp_armed,
   output logic [1:0]            rsp_mode_event,
   output logic [TIME_W-1:0]     rsp_sampling_end,
   output logic [CNT_W-1:0]      rsp_sniff_drop_sum,
   output logic                  rsp_new_raw_out_drops,
   output logic                  rsp_new_ignored_out_drops,
   output logic                  rsp_new_capture_drops,
   output logic                  rsp_new_matcher_drops,
   output logic                  rsp_new_encoder_drops,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NUM_CNT     = 7;
   localparam int IDX_SNIFFED = 0;
   localparam int IDX_SDROP   = 1;
   localparam int IDX_RAW     = 2;
   localparam int IDX_ENC     = 3;
   localparam int IDX_MATCH   = 4;
   localparam int IDX_RAWOUT  = 5;
   localparam int IDX_IGNOUT  = 6;
   localparam int NUM_PAIR    = 3;
   localparam int PCT_SCALE   = 100;

   // Configuration registers
   logic                present_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [CFG16_W-1:0]  rate_ff;
   logic [CFG16_W-1:0]  dur_ff;

   // Handshake
   logic rsp_ok, s3_ready, s2_ready, s1_ready;
   logic s1_go, s3_go;

   // Stage 1: input register
   logic                s1_valid_ff;
   logic [TIME_W-1:0]   s1_now_ff;
   logic [CNT_W-1:0]    s1_cnt_ff [NUM_CNT];
   logic [CNT_W-1:0]    cnt_req [NUM_CNT];

   // Snapshot and running total
   logic [CNT_W-1:0]    prev_ff [NUM_CNT];
   logic [CNT_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    delta [NUM_CNT];
   drop_flags_type      flags_new;

   // Stage 2: deltas
   logic                s2_valid_ff;
   logic [TIME_W-1:0]   s2_now_ff;
   logic [CNT_W-1:0]    s2_drop_ff [NUM_PAIR];
   logic [CNT_W-1:0]    s2_arr_ff [NUM_PAIR];
   drop_flags_type      s2_flags_ff;
   logic [CNT_W-1:0]    s2_sum_ff;

   // Stage 3: scaled products
   logic                s3_valid_ff;
   logic [TIME_W-1:0]   s3_now_ff;
   logic [PROD_W-1:0]   s3_drop_prod_ff [NUM_PAIR];
   logic [PROD_W-1:0]   s3_arr_prod_ff [NUM_PAIR];
   drop_flags_type      s3_flags_ff;
   logic [CNT_W-1:0]    s3_sum_ff;

   // Result register
   logic                rsp_valid_ff;
   drop_flags_type      rsp_flags_ff;
   logic [CNT_W-1:0]    rsp_sum_ff;

   logic [NUM_PAIR-1:0] over_pair;
   mode_req_type        mode_req;
   mode_stat_type       mode_stat;

   // Write configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= PRESENT_RST;
         thresh_ff  <= THRESHOLD_RST;
         rate_ff    <= RATE_RST;
         dur_ff     <= DURATION_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PRESENT:   present_ff <= csr_wdata[0];
            CSR_THRESHOLD: thresh_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_RATE:      rate_ff    <= csr_wdata[CFG16_W-1:0];
            CSR_DURATION:  dur_ff     <= csr_wdata[CFG16_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Stall chain: a stage moves on when the next one is empty or moving
   assign rsp_ok    = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || rsp_ok;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign s1_go     = s1_valid_ff && s2_ready;
   assign s3_go     = s3_valid_ff && rsp_ok;

   assign cnt_req[IDX_SNIFFED] = req_sniffed_total;
   assign cnt_req[IDX_SDROP]   = req_sniff_dropped_total;
   assign cnt_req[IDX_RAW]     = req_raw_total;
   assign cnt_req[IDX_ENC]     = req_encoder_drop_total;
   assign cnt_req[IDX_MATCH]   = req_matcher_drop_total;
   assign cnt_req[IDX_RAWOUT]  = req_raw_out_drop_total;
   assign cnt_req[IDX_IGNOUT]  = req_ignored_out_drop_total;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_now_ff <= req_now_seconds;
         for (int i = 0; i < NUM_CNT; i++) begin
            s1_cnt_ff[i] <= cnt_req[i];
         end
      end
   end

   // Wrapping deltas against the previous snapshot
   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         delta[i] = s1_cnt_ff[i] - prev_ff[i];
      end
      flags_new.raw_out = present_ff && (delta[IDX_RAWOUT] != '0);
      flags_new.ign_out = present_ff && (delta[IDX_IGNOUT] != '0);
      flags_new.sniff   = present_ff && (delta[IDX_SDROP] != '0);
      flags_new.match   = present_ff && (delta[IDX_MATCH] != '0);
      flags_new.enc     = present_ff && (delta[IDX_ENC] != '0);
      acc_in = acc_ff + delta[IDX_SDROP];
   end

   // Advance snapshot and drop total when the sniffer is present
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int i = 0; i < NUM_CNT; i++) begin
            prev_ff[i] <= '0;
         end
      end else if (s1_go && present_ff) begin
         acc_ff <= acc_in;
         for (int i = 0; i < NUM_CNT; i++) begin
            prev_ff[i] <= s1_cnt_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_now_ff     <= s1_now_ff;
         s2_drop_ff[0] <= delta[IDX_SDROP];
         s2_arr_ff[0]  <= delta[IDX_SNIFFED];
         s2_drop_ff[1] <= delta[IDX_ENC];
         s2_arr_ff[1]  <= delta[IDX_RAW];
         s2_drop_ff[2] <= delta[IDX_MATCH];
         s2_arr_ff[2]  <= delta[IDX_RAW];
         s2_flags_ff   <= flags_new;
         s2_sum_ff     <= present_ff ? acc_in : acc_ff;
      end
   end

   // Scale drops by 100 and arrivals by the threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_now_ff   <= s2_now_ff;
         s3_flags_ff <= s2_flags_ff;
         s3_sum_ff   <= s2_sum_ff;
         for (int p = 0; p < NUM_PAIR; p++) begin
            s3_drop_prod_ff[p] <= PROD_W'(s2_drop_ff[p]) * PROD_W'(PCT_SCALE);
            s3_arr_prod_ff[p]  <= PROD_W'(s2_arr_ff[p]) * PROD_W'(thresh_ff);
         end
      end
   end

   // Overload when any drop share exceeds the threshold
   always_comb begin
      for (int p = 0; p < NUM_PAIR; p++) begin
         over_pair[p] = s3_drop_prod_ff[p] > s3_arr_prod_ff[p];
      end
      mode_req.load     = s3_go;
      mode_req.present  = present_ff;
      mode_req.overload = |over_pair;
      mode_req.rate_nz  = (rate_ff != '0);
      mode_req.now      = s3_now_ff;
      mode_req.duration = dur_ff;
   end

   dtsc_mode_ctrl u_mode_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (mode_req),
      .stat  (mode_stat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ok) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ok) begin
         rsp_flags_ff <= s3_flags_ff;
         rsp_sum_ff   <= s3_sum_ff;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_sampling_on           = mode_stat.sampling_on;
   assign rsp_armed                 = mode_stat.armed;
   assign rsp_mode_event            = mode_stat.event_code;
   assign rsp_sampling_end          = mode_stat.sampling_end;
   assign rsp_sniff_drop_sum        = rsp_sum_ff;
   assign rsp_new_raw_out_drops     = rsp_flags_ff.raw_out;
   assign rsp_new_ignored_out_drops = rsp_flags_ff.ign_out;
   assign rsp_new_capture_drops     = rsp_flags_ff.sniff;
   assign rsp_new_matcher_drops     = rsp_flags_ff.match;
   assign rsp_new_encoder_drops     = rsp_flags_ff.enc;

endmodule

// ===== rtl/dtsc_mode_ctrl.sv =====
module dtsc_mode_ctrl
   import dtsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mode_req_type  req,
   output mode_stat_type stat
);

   mode_state_type      state_ff, state_in;
   logic [TIME_W-1:0]   end_ff, end_in;
   mode_event_type      event_ff, event_in;

   logic [TIME_W:0]     end_sum;
   logic [TIME_W-1:0]   end_new;
   logic                expired;

   // New end time, saturating at the top of the time range
   assign end_sum = {1'b0, req.now} + (TIME_W+1)'(req.duration);
   assign end_new = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
   assign expired = (end_ff <= req.now);

   // Next state: arm, switch on, extend, switch off
   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      event_in = event_ff;
      if (req.load) begin
         event_in = EV_NONE;
         if (req.present) begin
            if (req.overload) begin
               if (req.rate_nz) begin
                  case (state_ff)
                     MODE_OFF: begin
                        state_in = MODE_ARMED;
                     end
                     MODE_ARMED: begin
                        state_in = MODE_SAMPLING;
                        end_in   = end_new;
                        event_in = EV_ON;
                     end
                     MODE_SAMPLING: begin
                        if (expired) begin
                           end_in   = end_new;
                           event_in = EV_EXTEND;
                        end
                     end
                     default: begin
                        state_in = MODE_OFF;
                     end
                  endcase
               end
            end else if (state_ff == MODE_SAMPLING && expired) begin
               state_in = MODE_OFF;
               event_in = EV_OFF;
            end
         end
      end
   end

   // Hold mode, end time and last event
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MODE_OFF;
         end_ff   <= '0;
         event_ff <= EV_NONE;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         event_ff <= event_in;
      end
   end

   // Drive status; the arm flag stays set while sampling
   always_comb begin
      stat.sampling_on  = (state_ff == MODE_SAMPLING);
      stat.armed        = (state_ff == MODE_ARMED) || (state_ff == MODE_SAMPLING);
      stat.event_code   = event_ff;
      stat.sampling_end = end_ff;
   end

endmodule

// ===== rtl/dtsc_checker.sv =====
module dtsc_checker
   import dtsc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_sampling_on,
   input logic              rsp_armed,
   input logic [1:0]        rsp_mode_event,
   input logic [TIME_W-1:0] rsp_sampling_end
);

   // Switch-on and extension leave sampling active
   a_on_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_event == EV_ON || rsp_mode_event == EV_EXTEND)
      |-> rsp_sampling_on)
      else $error("sampling not active after switch-on or extension");

   // Switch-off clears sampling and the arm flag together
   a_off_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_event == EV_OFF |-> !rsp_sampling_on && !rsp_armed)
      else $error("state left set after switch-off");

   // Sampling is only ever on while armed
   a_on_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_sampling_on |-> rsp_armed)
      else $error("sampling active without arm flag");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sampling_end)
         && $stable(rsp_mode_event))
      else $error("stalled result changed");

endmodule

bind drop_triggered_sampling_control dtsc_checker u_dtsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sampling_on  (rsp_sampling_on),
   .rsp_armed        (rsp_armed),
   .rsp_mode_event   (rsp_mode_event),
   .rsp_sampling_end (rsp_sampling_end)
);
